// File: sv/fcgl_pkg.sv
`timescale 1ns / 1ps

package fcgl_pkg;

  localparam int ADDR_W = 24;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK,
    S_FETCH,
    S_GOT_LEN,
    S_GOT_CNT,
    S_LENCHK,
    S_LOOP,
    S_PROBE_ADDR,
    S_GOT_PROBE,
    S_GOT_END,
    S_GOT_START,
    S_RANGECHK,
    S_GOT_DELTA,
    S_GOT_IRO,
    S_IROCHK,
    S_GOT_GLYPH,
    S_ZERO,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    A_LEN,
    A_CNT,
    A_PROBE,
    A_END,
    A_START,
    A_DELTA,
    A_RANGE,
    A_GLYPH
  } addr_sel_t;

  typedef enum logic [2:0] {
    D_LEN,
    D_CNT,
    D_END,
    D_START,
    D_DELTA,
    D_IRO
  } dst_t;

  typedef enum logic [1:0] {
    R_ZERO,
    R_DIRECT,
    R_GLYPH,
    R_GROUP
  } res_sel_t;

  typedef struct packed {
    logic      fetch;
    logic      addr_ld;
    addr_sel_t asel;
    logic      save;
    dst_t      dst;
    logic      loop_init;
    logic      mid_ld;
    logic      step;
    logic      res_ld;
    res_sel_t  rsel;
    logic      push;
  } dp_cmd_t;

  typedef struct packed {
    logic is4;
    logic is12;
    logic cp_big;
    logic fault;
    logic fetch_done;
    logic len_bad;
    logic lo_lt_hi;
    logic lo_ge_segs;
    logic probe_lt;
    logic out_range;
    logic iro_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/fcgl_ram.sv
`timescale 1ns / 1ps

module fcgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/fcgl_ctrl.sv
`timescale 1ns / 1ps

module fcgl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               lookup,
  input  fcgl_pkg::dp_stat_t stat,
  output fcgl_pkg::dp_cmd_t  cmd,
  output logic               idle
);

  fcgl_pkg::state_t state, state_next, ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcgl_pkg::S_IDLE;
      ret   <= fcgl_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      fcgl_pkg::S_IDLE: if (lookup) state_next = fcgl_pkg::S_DISPATCH;
      fcgl_pkg::S_DISPATCH: begin
        if (!(stat.is4 || stat.is12) || (stat.is4 && stat.cp_big)) begin
          state_next = fcgl_pkg::S_ZERO;
        end else begin
          state_next = fcgl_pkg::S_CHK;
          ret_next   = fcgl_pkg::S_GOT_LEN;
        end
      end
      fcgl_pkg::S_CHK: state_next = stat.fault ? fcgl_pkg::S_ZERO : fcgl_pkg::S_FETCH;
      fcgl_pkg::S_FETCH: if (stat.fetch_done) state_next = ret;
      fcgl_pkg::S_GOT_LEN: begin
        state_next = fcgl_pkg::S_CHK;
        ret_next   = fcgl_pkg::S_GOT_CNT;
      end
      fcgl_pkg::S_GOT_CNT: state_next = fcgl_pkg::S_LENCHK;
      fcgl_pkg::S_LENCHK: state_next = stat.len_bad ? fcgl_pkg::S_ZERO : fcgl_pkg::S_LOOP;
      fcgl_pkg::S_LOOP: begin
        if (stat.lo_lt_hi) begin
          state_next = fcgl_pkg::S_PROBE_ADDR;
        end else if (stat.lo_ge_segs) begin
          state_next = fcgl_pkg::S_ZERO;
        end else begin
          state_next = fcgl_pkg::S_CHK;
          ret_next   = fcgl_pkg::S_GOT_END;
        end
      end
      fcgl_pkg::S_PROBE_ADDR: begin
        state_next = fcgl_pkg::S_CHK;
        ret_next   = fcgl_pkg::S_GOT_PROBE;
      end
      fcgl_pkg::S_GOT_PROBE: state_next = fcgl_pkg::S_LOOP;
      fcgl_pkg::S_GOT_END: begin
        state_next = fcgl_pkg::S_CHK;
        ret_next   = fcgl_pkg::S_GOT_START;
      end
      fcgl_pkg::S_GOT_START: state_next = fcgl_pkg::S_RANGECHK;
      fcgl_pkg::S_RANGECHK: begin
        if (stat.out_range) begin
          state_next = fcgl_pkg::S_ZERO;
        end else begin
          state_next = fcgl_pkg::S_CHK;
          ret_next   = fcgl_pkg::S_GOT_DELTA;
        end
      end
      fcgl_pkg::S_GOT_DELTA: begin
        if (stat.is12) begin
          state_next = fcgl_pkg::S_DONE;
        end else begin
          state_next = fcgl_pkg::S_CHK;
          ret_next   = fcgl_pkg::S_GOT_IRO;
        end
      end
      fcgl_pkg::S_GOT_IRO: state_next = fcgl_pkg::S_IROCHK;
      fcgl_pkg::S_IROCHK: begin
        if (stat.iro_zero) begin
          state_next = fcgl_pkg::S_DONE;
        end else begin
          state_next = fcgl_pkg::S_CHK;
          ret_next   = fcgl_pkg::S_GOT_GLYPH;
        end
      end
      fcgl_pkg::S_GOT_GLYPH: state_next = fcgl_pkg::S_DONE;
      fcgl_pkg::S_ZERO: state_next = fcgl_pkg::S_DONE;
      fcgl_pkg::S_DONE: if (stat.out_free) state_next = fcgl_pkg::S_IDLE;
      default: state_next = fcgl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state)
      fcgl_pkg::S_IDLE: idle = 1'b1;
      fcgl_pkg::S_DISPATCH: begin
        cmd.addr_ld = 1'b1;
        cmd.asel    = fcgl_pkg::A_LEN;
      end
      fcgl_pkg::S_FETCH: cmd.fetch = 1'b1;
      fcgl_pkg::S_GOT_LEN: begin
        cmd.save    = 1'b1;
        cmd.dst     = fcgl_pkg::D_LEN;
        cmd.addr_ld = 1'b1;
        cmd.asel    = fcgl_pkg::A_CNT;
      end
      fcgl_pkg::S_GOT_CNT: begin
        cmd.save = 1'b1;
        cmd.dst  = fcgl_pkg::D_CNT;
      end
      fcgl_pkg::S_LENCHK: cmd.loop_init = 1'b1;
      fcgl_pkg::S_LOOP: begin
        cmd.mid_ld  = stat.lo_lt_hi;
        cmd.addr_ld = !stat.lo_lt_hi;
        cmd.asel    = fcgl_pkg::A_END;
      end
      fcgl_pkg::S_PROBE_ADDR: begin
        cmd.addr_ld = 1'b1;
        cmd.asel    = fcgl_pkg::A_PROBE;
      end
      fcgl_pkg::S_GOT_PROBE: cmd.step = 1'b1;
      fcgl_pkg::S_GOT_END: begin
        cmd.save    = 1'b1;
        cmd.dst     = fcgl_pkg::D_END;
        cmd.addr_ld = 1'b1;
        cmd.asel    = fcgl_pkg::A_START;
      end
      fcgl_pkg::S_GOT_START: begin
        cmd.save = 1'b1;
        cmd.dst  = fcgl_pkg::D_START;
      end
      fcgl_pkg::S_RANGECHK: begin
        cmd.addr_ld = 1'b1;
        cmd.asel    = fcgl_pkg::A_DELTA;
      end
      fcgl_pkg::S_GOT_DELTA: begin
        cmd.res_ld  = stat.is12;
        cmd.rsel    = fcgl_pkg::R_GROUP;
        cmd.save    = 1'b1;
        cmd.dst     = fcgl_pkg::D_DELTA;
        cmd.addr_ld = !stat.is12;
        cmd.asel    = fcgl_pkg::A_RANGE;
      end
      fcgl_pkg::S_GOT_IRO: begin
        cmd.save = 1'b1;
        cmd.dst  = fcgl_pkg::D_IRO;
      end
      fcgl_pkg::S_IROCHK: begin
        cmd.res_ld  = stat.iro_zero;
        cmd.rsel    = fcgl_pkg::R_DIRECT;
        cmd.addr_ld = !stat.iro_zero;
        cmd.asel    = fcgl_pkg::A_GLYPH;
      end
      fcgl_pkg::S_GOT_GLYPH: begin
        cmd.res_ld = 1'b1;
        cmd.rsel   = fcgl_pkg::R_GLYPH;
      end
      fcgl_pkg::S_ZERO: begin
        cmd.res_ld = 1'b1;
        cmd.rsel   = fcgl_pkg::R_ZERO;
      end
      fcgl_pkg::S_DONE: cmd.push = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/fcgl_dp.sv
`timescale 1ns / 1ps

module fcgl_dp #(
  parameter int STORE_BYTES = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  fcgl_pkg::dp_cmd_t  cmd,
  output fcgl_pkg::dp_stat_t stat,
  input  logic               lookup,
  input  logic               wr,
  input  logic [13:0]        byte_address,
  input  logic [7:0]         byte_value,
  input  logic [31:0]        codepoint,
  input  logic [3:0]         table_format,
  input  logic [14:0]        table_bytes,
  output logic [15:0]        glyph_number,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int W  = fcgl_pkg::ADDR_W;

  logic [31:0]   cp, len, cnt, lo, hi, mid, word, startc, endc;
  logic [14:0]   limit;
  logic          is4, is12, pend;
  logic [W-1:0]  faddr, addr_sel, seg2, lo24, mid24, lo12, mid12;
  logic [15:0]   delta, iro, res;
  logic [2:0]    bcnt, nb;
  logic          issue, ram_we;
  logic [7:0]    rdata;
  logic [AW-1:0] ram_addr;
  logic [31:0]   segs;
  logic [36:0]   grp_need;
  logic [W:0]    last;

  assign nb    = is12 ? 3'd4 : 3'd2;
  assign issue = cmd.fetch && (bcnt != nb);
  assign ram_we = wr && ({18'b0, byte_address} < 32'(STORE_BYTES));
  assign ram_addr = ram_we ? AW'(byte_address) : AW'(faddr + W'(bcnt));

  fcgl_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (byte_value),
    .rdata (rdata)
  );

  assign seg2  = W'(cnt[15:0]);
  assign lo24  = lo[W-1:0];
  assign mid24 = mid[W-1:0];
  assign lo12  = {lo24[W-4:0], 3'b0} + {lo24[W-3:0], 2'b0};
  assign mid12 = {mid24[W-4:0], 3'b0} + {mid24[W-3:0], 2'b0};

  always_comb begin
    unique case (cmd.asel)
      fcgl_pkg::A_LEN:   addr_sel = is12 ? W'(4) : W'(2);
      fcgl_pkg::A_CNT:   addr_sel = is12 ? W'(12) : W'(6);
      fcgl_pkg::A_PROBE: addr_sel = is12 ? W'(20) + mid12 : W'(14) + {mid24[W-2:0], 1'b0};
      fcgl_pkg::A_END:   addr_sel = is12 ? W'(20) + lo12 : W'(14) + {lo24[W-2:0], 1'b0};
      fcgl_pkg::A_START: addr_sel = is12 ? W'(16) + lo12
                                         : W'(16) + seg2 + {lo24[W-2:0], 1'b0};
      fcgl_pkg::A_DELTA: addr_sel = is12 ? W'(24) + lo12
                                         : W'(16) + {seg2[W-2:0], 1'b0}
                                           + {lo24[W-2:0], 1'b0};
      fcgl_pkg::A_RANGE: addr_sel = W'(16) + seg2 + {seg2[W-2:0], 1'b0}
                                    + {lo24[W-2:0], 1'b0};
      fcgl_pkg::A_GLYPH: addr_sel = faddr + W'(iro)
                                    + W'({cp[15:0] - startc[15:0], 1'b0});
      default:           addr_sel = faddr;
    endcase
  end

  assign segs     = is12 ? cnt : {17'b0, cnt[15:1]};
  assign grp_need = 37'({cnt, 3'b0}) + 37'({cnt, 2'b0}) + 37'd16;
  assign last     = {1'b0, faddr} + (is12 ? (W+1)'(3) : (W+1)'(1));

  always_comb begin
    stat.is4        = is4;
    stat.is12       = is12;
    stat.cp_big     = cp[31:16] != 16'd0;
    stat.fault      = last >= (W+1)'(limit);
    stat.fetch_done = cmd.fetch && pend && (bcnt == nb);
    stat.len_bad    = (len > 32'(limit)) || (is12 && (37'(len) < grp_need));
    stat.lo_lt_hi   = lo < hi;
    stat.lo_ge_segs = lo >= segs;
    stat.probe_lt   = word < cp;
    stat.out_range  = (cp < startc) || (cp > endc);
    stat.iro_zero   = iro == 16'd0;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      is4       <= 1'b0;
      is12      <= 1'b0;
    end else begin
      if (lookup) begin
        is4  <= table_format == 4'd4;
        is12 <= table_format == 4'd12;
      end
      if (!cmd.fetch) begin
        bcnt <= '0;
        pend <= 1'b0;
      end else begin
        pend <= issue;
        if (issue) bcnt <= bcnt + 3'd1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      cp <= codepoint;
      if (32'(table_bytes) > 32'(STORE_BYTES)) limit <= 15'(STORE_BYTES);
      else limit <= table_bytes;
    end
    if (cmd.addr_ld) begin
      faddr <= addr_sel;
      word  <= '0;
    end else if (cmd.fetch && pend) begin
      word <= {word[23:0], rdata};
    end
    if (cmd.save) begin
      unique case (cmd.dst)
        fcgl_pkg::D_LEN:   len    <= word;
        fcgl_pkg::D_CNT:   cnt    <= word;
        fcgl_pkg::D_END:   endc   <= word;
        fcgl_pkg::D_START: startc <= word;
        fcgl_pkg::D_DELTA: delta  <= word[15:0];
        fcgl_pkg::D_IRO:   iro    <= word[15:0];
        default:           len    <= len;
      endcase
    end
    if (cmd.loop_init) begin
      lo <= '0;
      hi <= segs;
    end
    if (cmd.mid_ld) mid <= lo + ((hi - lo) >> 1);
    if (cmd.step) begin
      if (stat.probe_lt) lo <= mid + 32'd1;
      else hi <= mid;
    end
    if (cmd.res_ld) begin
      unique case (cmd.rsel)
        fcgl_pkg::R_ZERO:   res <= '0;
        fcgl_pkg::R_DIRECT: res <= cp[15:0] + delta;
        fcgl_pkg::R_GLYPH:  res <= (word[15:0] == 16'd0) ? 16'd0 : word[15:0] + delta;
        fcgl_pkg::R_GROUP:  res <= word[15:0] + cp[15:0] - startc[15:0];
        default:            res <= '0;
      endcase
    end
    if (cmd.push) glyph_number <= res;
  end

endmodule

// File: sv/font_cmap_glyph_lookup.sv
`timescale 1ns / 1ps

// Maps a codepoint to a glyph number through a format 4 or format 12 character-map
// subtable held in a single-port byte store. A byte write request does not make the
// block busy. A lookup request reads the length and count words, then
// binary-searches. Every word read passes a bound-check state, a fetch state that
// reads its bytes in turn, and a capture state, all through the one store port.
// A search probe adds a loop state and an address state. An unsupported format, an
// out-of-range codepoint or a bad header gives a zero result. The result waits in
// an output register; one lookup is in flight at a time.
module font_cmap_glyph_lookup #(
  parameter int STORE_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [13:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [31:0] codepoint,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] glyph_number
);

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_BYTES  = 1'b1;

  logic [3:0]         table_format;
  logic [14:0]        table_bytes;
  logic               idle, lookup, wr;
  fcgl_pkg::dp_cmd_t  cmd;
  fcgl_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign lookup    = in_valid && in_ready && operation;
  assign wr        = in_valid && in_ready && !operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_format <= '0;
      table_bytes  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORMAT: table_format <= cfg_data[3:0];
        REG_BYTES:  table_bytes  <= cfg_data;
        default:    table_bytes  <= table_bytes;
      endcase
    end
  end

  fcgl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .lookup (lookup),
    .stat   (stat),
    .cmd    (cmd),
    .idle   (idle)
  );

  fcgl_dp #(.STORE_BYTES(STORE_BYTES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .lookup       (lookup),
    .wr           (wr),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .codepoint    (codepoint),
    .table_format (table_format),
    .table_bytes  (table_bytes),
    .glyph_number (glyph_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    lookup |=> !in_ready)
    else $error("lookup request did not make the block busy");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    wr |=> in_ready)
    else $error("byte write request stalled the input");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// File: sim/font_cmap_glyph_lookup_tb_pkg.sv
`timescale 1ns / 1ps

package font_cmap_glyph_lookup_tb_pkg;

  localparam bit OP_LOAD   = 1'b0;
  localparam bit OP_LOOKUP = 1'b1;

  localparam bit REG_FORMAT = 1'b0;
  localparam bit REG_BYTES  = 1'b1;

  localparam int unsigned FMT_NONE   = 0;
  localparam int unsigned FMT_SEGMAP = 4;
  localparam int unsigned FMT_GROUPS = 12;
  localparam int unsigned FMT_MAX    = 15;

  localparam int unsigned STORE_SIZE = 16384;

endpackage

// File: sim/font_cmap_glyph_lookup_chk.sv
`timescale 1ns / 1ps

module font_cmap_glyph_lookup_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [13:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [31:0] codepoint,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] glyph_number,
  output int          errors,
  output int          pending
);

  bit [7:0]    table_mem [0:font_cmap_glyph_lookup_tb_pkg::STORE_SIZE-1];
  bit [3:0]    fmt_reg;
  bit [14:0]   bytes_reg;
  int unsigned read_lim;
  bit          read_bad;
  bit [15:0]   pending_glyphs [$];

  function automatic int unsigned rd8(int unsigned a);
    if (a >= read_lim) begin
      read_bad = 1'b1;
      return 0;
    end
    return table_mem[a];
  endfunction

  function automatic int unsigned rd16(int unsigned a);
    return (rd8(a) << 8) | rd8(a + 1);
  endfunction

  function automatic int unsigned rd32(int unsigned a);
    return (rd16(a) << 16) | rd16(a + 2);
  endfunction

  function automatic int unsigned segmap_glyph(int unsigned cp);
    int unsigned len, segx2, segs, starts, deltas, ranges;
    int unsigned lo, hi, mid, end_c, start_c, delta, iro, g;
    if (cp > 32'hFFFF) return 0;
    len   = rd16(2);
    segx2 = rd16(6);
    if (read_bad || len > read_lim) return 0;
    segs   = segx2 / 2;
    starts = 14 + segx2 + 2;
    deltas = starts + segx2;
    ranges = deltas + segx2;
    lo = 0;
    hi = segs;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (rd16(14 + mid * 2) < cp) lo = mid + 1; else hi = mid;
      if (read_bad) return 0;
    end
    if (lo >= segs) return 0;
    end_c   = rd16(14 + lo * 2);
    start_c = rd16(starts + lo * 2);
    if (read_bad || cp < start_c || cp > end_c) return 0;
    delta = rd16(deltas + lo * 2);
    iro   = rd16(ranges + lo * 2);
    if (read_bad) return 0;
    if (iro == 0) return (cp + delta) & 32'hFFFF;
    g = rd16(ranges + lo * 2 + iro + (cp - start_c) * 2);
    if (read_bad) return 0;
    if (g != 0) g = (g + delta) & 32'hFFFF;
    return g;
  endfunction

  function automatic int unsigned group_glyph(int unsigned cp);
    int unsigned len, groups, lo, hi, mid, base, start_c, end_c, first_g;
    len    = rd32(4);
    groups = rd32(12);
    if (read_bad || len > read_lim) return 0;
    if (longint'(len) < 64'd16 + longint'(groups) * 64'd12) return 0;
    lo = 0;
    hi = groups;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (rd32(16 + mid * 12 + 4) < cp) lo = mid + 1; else hi = mid;
      if (read_bad) return 0;
    end
    if (lo >= groups) return 0;
    base    = 16 + lo * 12;
    start_c = rd32(base);
    end_c   = rd32(base + 4);
    first_g = rd32(base + 8);
    if (read_bad || cp < start_c || cp > end_c) return 0;
    return (first_g + (cp - start_c)) & 32'hFFFF;
  endfunction

  function automatic bit [15:0] map_glyph(int unsigned cp);
    int unsigned g;
    g = 0;
    read_lim = (bytes_reg < font_cmap_glyph_lookup_tb_pkg::STORE_SIZE) ?
               bytes_reg : font_cmap_glyph_lookup_tb_pkg::STORE_SIZE;
    read_bad = 1'b0;
    if (fmt_reg == font_cmap_glyph_lookup_tb_pkg::FMT_SEGMAP) g = segmap_glyph(cp);
    else if (fmt_reg == font_cmap_glyph_lookup_tb_pkg::FMT_GROUPS) g = group_glyph(cp);
    return g[15:0];
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bit [15:0] want;
    if (rst) begin
      fmt_reg   = '0;
      bytes_reg = '0;
      pending_glyphs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_glyphs.size() == 0) begin
          errors++;
          $display("%0t: unexpected glyph result, expected none, actual %h",
                   $realtime, glyph_number);
        end else begin
          want = pending_glyphs.pop_front();
          if (glyph_number !== want) begin
            errors++;
            $display("%0t: glyph_number expected %h, actual %h",
                     $realtime, want, glyph_number);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == font_cmap_glyph_lookup_tb_pkg::REG_FORMAT) fmt_reg = cfg_data[3:0];
        else bytes_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (operation == font_cmap_glyph_lookup_tb_pkg::OP_LOAD)
          table_mem[byte_address] = byte_value;
        else
          pending_glyphs.push_back(map_glyph(codepoint));
      end
    end
    pending = pending_glyphs.size();
  end

endmodule

// File: sim/font_cmap_glyph_lookup_tb.sv
`timescale 1ns / 1ps

module font_cmap_glyph_lookup_tb;

  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [13:0] byte_address;
  logic [7:0]  byte_value;
  logic [31:0] codepoint;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] glyph_number;
  int          errors;
  int          pending;

  bit          gaps_on;
  int          stall_left;
  int          idle_cycles;

  bit [7:0]    img [0:font_cmap_glyph_lookup_tb_pkg::STORE_SIZE-1];
  int unsigned seg_lo [0:31];
  int unsigned seg_hi [0:31];
  int          nsegs;
  int          tbl_w;

  font_cmap_glyph_lookup dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .byte_address(byte_address), .byte_value(byte_value), .codepoint(codepoint),
    .out_valid(out_valid), .out_ready(out_ready), .glyph_number(glyph_number)
  );

  font_cmap_glyph_lookup_chk chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .byte_address(byte_address), .byte_value(byte_value), .codepoint(codepoint),
    .out_valid(out_valid), .out_ready(out_ready), .glyph_number(glyph_number),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // result-side back-pressure
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      out_ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send(input bit op, input bit [13:0] a, input bit [7:0] v,
                      input bit [31:0] cp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid     = 1'b1;
    operation    = op;
    byte_address = a;
    byte_value   = v;
    codepoint    = cp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input bit idx, input int unsigned v);
    drain();
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_data  = v[14:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic lookup(input bit [31:0] cp);
    send(font_cmap_glyph_lookup_tb_pkg::OP_LOOKUP, 14'($urandom), 8'($urandom), cp);
  endtask

  task automatic put16(input int a, input int unsigned v);
    img[a]     = v[15:8];
    img[a + 1] = v[7:0];
  endtask

  task automatic put32(input int a, input int unsigned v);
    put16(a, v >> 16);
    put16(a + 2, v & 32'hFFFF);
  endtask

  task automatic load_table();
    for (int a = 0; a < tbl_w; a++)
      send(font_cmap_glyph_lookup_tb_pkg::OP_LOAD, 14'(a), img[a], $urandom);
  endtask

  // segment map; bad_len declares a length past the usable size
  task automatic build_segmap(input bit odd_cnt, input bit bad_len);
    int unsigned cur, s, e, segx2, starts, deltas, ranges, garr, len, nglyph, k;
    cur   = $urandom_range(0, 300);
    nsegs = 0;
    for (int i = 0; i < $urandom_range(1, 12); i++) begin
      s = cur + $urandom_range(0, 4000);
      if (s > 32'hFFFF) break;
      e = s + $urandom_range(0, 40);
      if (e > 32'hFFFF) e = 32'hFFFF;
      seg_lo[nsegs] = s;
      seg_hi[nsegs] = e;
      nsegs++;
      cur = e + 1;
      if (cur > 32'hFFFF) break;
    end
    if ($urandom_range(0, 1) == 0 && seg_hi[nsegs-1] != 32'hFFFF) begin
      seg_lo[nsegs] = 32'hFFFF;
      seg_hi[nsegs] = 32'hFFFF;
      nsegs++;
    end
    nglyph = $urandom_range(4, 24);
    segx2  = 2 * nsegs;
    starts = 16 + segx2;
    deltas = starts + segx2;
    ranges = deltas + segx2;
    garr   = ranges + segx2;
    len    = garr + 2 * nglyph;
    tbl_w  = len + $urandom_range(0, 6);
    for (int a = 0; a < tbl_w; a++) img[a] = 8'($urandom);
    put16(0, font_cmap_glyph_lookup_tb_pkg::FMT_SEGMAP);
    put16(2, bad_len ? tbl_w + 1 : len);
    put16(6, odd_cnt ? segx2 + 1 : segx2);
    put16(14 + segx2, 0);
    for (int i = 0; i < nsegs; i++) begin
      put16(14 + 2 * i, seg_hi[i]);
      put16(starts + 2 * i, seg_lo[i]);
      put16(deltas + 2 * i, $urandom_range(0, 16'hFFFF));
      k = $urandom_range(0, nglyph - 1);
      put16(ranges + 2 * i, ($urandom_range(0, 1) == 0) ? 0 : segx2 - 2 * i + 2 * k);
    end
    for (int j = 0; j < nglyph; j++)
      put16(garr + 2 * j, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16'hFFFF));
    load_table();
  endtask

  task automatic build_groups(input int want, input bit short_len);
    longint unsigned cur, s, e;
    cur   = $urandom_range(0, 1000);
    nsegs = 0;
    for (int i = 0; i < want; i++) begin
      s = cur + $urandom_range(0, 1 << 26);
      if (s > 64'hFFFF_FFFF) break;
      e = s + $urandom_range(0, 3000);
      if (i == want - 1 && $urandom_range(0, 1) == 0) e = 64'hFFFF_FFFF;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      seg_lo[nsegs] = s[31:0];
      seg_hi[nsegs] = e[31:0];
      nsegs++;
      cur = e + 1;
      if (cur > 64'hFFFF_FFFF) break;
    end
    tbl_w = 16 + 12 * nsegs;
    put16(0, font_cmap_glyph_lookup_tb_pkg::FMT_GROUPS);
    put16(2, 0);
    put32(4, short_len ? tbl_w - 1 : tbl_w);
    put32(8, $urandom);
    put32(12, nsegs);
    for (int i = 0; i < nsegs; i++) begin
      put32(16 + 12 * i, seg_lo[i]);
      put32(20 + 12 * i, seg_hi[i]);
      put32(24 + 12 * i, $urandom);
    end
    load_table();
  endtask

  function automatic bit [31:0] pick_cp(input bit wide);
    int r, k;
    r = $urandom_range(0, 19);
    k = (nsegs > 0) ? $urandom_range(0, nsegs - 1) : 0;
    if (nsegs > 0 && r < 12) return seg_lo[k] + $urandom_range(0, seg_hi[k] - seg_lo[k]);
    if (nsegs > 0 && r < 14) return (r == 12) ? seg_lo[k] - 1 : seg_hi[k] + 1;
    if (r < 17) return wide ? $urandom : $urandom_range(0, 16'hFFFF);
    if (r == 17) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF;
      2: return 32'h1_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // lookups mixed with stray loads; guard_lo keeps stray loads off the header
  task automatic run_mix(input int count, input bit wide, input int guard_lo);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      if ($urandom_range(0, 3) != 0) lookup(pick_cp(wide));
      else if ($urandom_range(0, 1) == 0 && tbl_w > guard_lo)
        send(font_cmap_glyph_lookup_tb_pkg::OP_LOAD,
             14'($urandom_range(guard_lo, tbl_w - 1)), 8'($urandom), $urandom);
      else
        send(font_cmap_glyph_lookup_tb_pkg::OP_LOAD,
             14'($urandom_range(tbl_w, font_cmap_glyph_lookup_tb_pkg::STORE_SIZE - 1)),
             8'($urandom), $urandom);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = font_cmap_glyph_lookup_tb_pkg::REG_FORMAT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    operation    = font_cmap_glyph_lookup_tb_pkg::OP_LOAD;
    byte_address = '0;
    byte_value   = '0;
    codepoint    = '0;
    gaps_on      = 1'b1;
    tbl_w        = 0;
    nsegs        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no table selected
    lookup(32'h41);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_FORMAT,
              font_cmap_glyph_lookup_tb_pkg::FMT_MAX);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, 0);
    lookup(32'hFFFF_FFFF);

    build_segmap(1'b0, 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_FORMAT,
              font_cmap_glyph_lookup_tb_pkg::FMT_SEGMAP);
    lookup(32'h0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    lookup(32'h0);
    lookup(32'hFFFF);
    lookup(32'h1_0000);
    lookup(32'hFFFF_FFFF);
    for (int i = 0; i < nsegs && i < 4; i++) begin
      lookup(seg_lo[i]);
      lookup(seg_hi[i]);
    end
    run_mix(200, 1'b0, 0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w - 3);
    run_mix(100, 1'b0, 0);

    build_segmap(1'b1, 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(120, 1'b0, 0);
    build_segmap(1'b0, 1'b1);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(40, 1'b0, 0);

    build_groups($urandom_range(8, 20), 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_FORMAT,
              font_cmap_glyph_lookup_tb_pkg::FMT_GROUPS);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(200, 1'b1, 0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, 0);
    run_mix(10, 1'b1, 0);

    // largest bound; header kept intact since reads then stop at the declared length
    build_groups($urandom_range(1, 20), 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES,
              font_cmap_glyph_lookup_tb_pkg::STORE_SIZE);
    send(font_cmap_glyph_lookup_tb_pkg::OP_LOAD,
         14'(font_cmap_glyph_lookup_tb_pkg::STORE_SIZE - 1), 8'hFF, 32'hFFFF_FFFF);
    run_mix(200, 1'b1, 16);

    build_groups(0, 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(20, 1'b1, 0);
    build_groups($urandom_range(2, 10), 1'b1);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(80, 1'b1, 0);

    build_segmap(1'b0, 1'b0);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_FORMAT,
              font_cmap_glyph_lookup_tb_pkg::FMT_SEGMAP);
    write_reg(font_cmap_glyph_lookup_tb_pkg::REG_BYTES, tbl_w);
    run_mix(150, 1'b0, 0);
    gaps_on = 1'b0;
    run_mix(200, 1'b0, 0);

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: font_cmap_glyph_lookup.f
sv/fcgl_pkg.sv
sv/fcgl_ram.sv
sv/fcgl_ctrl.sv
sv/fcgl_dp.sv
sv/font_cmap_glyph_lookup.sv
sim/font_cmap_glyph_lookup_tb_pkg.sv
sim/font_cmap_glyph_lookup_chk.sv
sim/font_cmap_glyph_lookup_tb.sv
